/* rtl/core/tlbpt_pkg.sv */
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths, types and state codes for the page translation block.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

   localparam int VA_WIDTH    = 20;
   localparam int PA_WIDTH    = 18;
   localparam int PAGE_WIDTH  = 10;
   localparam int FRAME_WIDTH = 8;
   localparam int OFS_WIDTH   = 10;
   localparam int STAMP_WIDTH = 32;

   localparam logic REPL_FIFO = 1'b0;
   localparam logic REPL_LRU  = 1'b1;

   typedef struct packed {
      logic [VA_WIDTH-1:0] virtual_address;
   } req_word_type;

   typedef struct packed {
      logic [PA_WIDTH-1:0]    phys_addr;
      logic [FRAME_WIDTH-1:0] frame_number;
      logic                   tlb_hit;
      logic                   page_fault;
      logic                   victim_valid;
      logic [PAGE_WIDTH-1:0]  victim_page;
   } rsp_word_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_TLB   = 8'b0000_0010,
      ST_SCAN  = 8'b0000_0100,
      ST_FREE  = 8'b0000_1000,
      ST_AGE   = 8'b0001_0000,
      ST_EVICT = 8'b0010_0000,
      ST_WRITE = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

endpackage

/* rtl/core/tlbpt_req_if.sv */
// ----------------------------------------------------------------------------
// tlbpt_req_if
// Request channel: valid/ready handshake carrying one virtual address word.
// ----------------------------------------------------------------------------
interface tlbpt_req_if;
   logic                  valid;
   logic                  ready;
   tlbpt_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/tlbpt_rsp_if.sv */
// ----------------------------------------------------------------------------
// tlbpt_rsp_if
// Response channel: valid/ready handshake carrying one translation word.
// ----------------------------------------------------------------------------
interface tlbpt_rsp_if;
   logic                  valid;
   logic                  ready;
   tlbpt_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/tlb_page_translate_fifo_lru_core.sv */
// ----------------------------------------------------------------------------
// tlb_page_translate_fifo_lru_core
// Virtual to physical translation through a small TLB and an inverted
// frame table held in synchronous memories, with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// req : one word per access, the 20-bit virtual address (page above offset).
// rsp : one word per request: physical address, frame, TLB hit, page fault
//       and the evicted page when a fault displaced a mapping.
// csr : csr_wr_en/csr_wr_data set the replacement rule (0 FIFO, 1 LRU);
//       write only while no request is outstanding.
// One request is in flight at a time. A TLB hit skips the frame table; a
// miss walks the owner memory until frame k matches, and a fault walks it
// to the end before eviction; under LRU with all frames in use the stamp
// memory is walked too. The single-port frame memory walk sets the rate.
// Reset (synchronous, active high) clears TLB valid bits, frame in-use bits,
// pointers, the access counter and the mode; owner pages, stamps and TLB
// contents stay, guarded by the in-use and valid bits.
// A stalled result holds in rsp.data until rsp.ready; req.ready returns the
// cycle after the result leaves.
// ----------------------------------------------------------------------------
module tlb_page_translate_fifo_lru_core #(
   parameter int TLB_ENTRIES = 16,
   parameter int FRAME_COUNT = 256
) (
   input  logic              clock,
   input  logic              reset,
   tlbpt_req_if.sink         req,
   tlbpt_rsp_if.source       rsp,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import tlbpt_pkg::*;

   localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int FW = $clog2(FRAME_COUNT);

   // configuration
   logic mode_ff;

   // TLB held in registers (small)
   logic                   tlb_valid_ff [TLB_ENTRIES];
   logic [PAGE_WIDTH-1:0]  tlb_page_ff  [TLB_ENTRIES];
   logic [FW-1:0]          tlb_frame_ff [TLB_ENTRIES];
   logic [TW-1:0]          tlb_fill_ff;

   // frame tables: owner page and stamp in memories, in-use bits in flops
   logic [PAGE_WIDTH-1:0]  owner_mem [FRAME_COUNT];
   logic [STAMP_WIDTH-1:0] stamp_mem [FRAME_COUNT];
   logic                   in_use_ff [FRAME_COUNT];
   logic [PAGE_WIDTH-1:0]  owner_rd;
   logic [STAMP_WIDTH-1:0] stamp_rd;

   logic [FW-1:0]          claim_ff;
   logic [STAMP_WIDTH-1:0] count_ff;

   state_type              state_ff;
   logic [VA_WIDTH-1:0]    va_ff;
   logic [FW:0]            idx_ff;      // walk index, one bit wider to end
   logic [FW-1:0]          rd_idx_ff;   // address whose data is in *_rd
   logic                   rd_vld_ff;
   logic [FW-1:0]          frame_ff;
   logic [FW-1:0]          best_ff;
   logic [STAMP_WIDTH-1:0] best_stamp_ff;
   logic                   hit_ff;
   logic                   fault_ff;
   rsp_word_type           rsp_ff;
   logic                   rsp_valid_ff;

   logic [PAGE_WIDTH-1:0]  page;
   logic                   tlb_hit_c;
   logic [FW-1:0]          tlb_frame_c;
   logic                   own_wr;
   logic                   stamp_wr;
   logic [FW-1:0]          mem_addr;

   assign page = va_ff[OFS_WIDTH +: PAGE_WIDTH];

   // lowest matching valid TLB entry wins
   always_comb begin
      tlb_hit_c   = 1'b0;
      tlb_frame_c = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && tlb_page_ff[i] == page) begin
            tlb_hit_c   = 1'b1;
            tlb_frame_c = tlb_frame_ff[i];
         end
      end
   end

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   assign own_wr   = (state_ff == ST_WRITE) && fault_ff;
   assign stamp_wr = (state_ff == ST_WRITE);
   assign mem_addr = (state_ff == ST_WRITE || state_ff == ST_EVICT) ? frame_ff
                                                                    : idx_ff[FW-1:0];

   // single-port memories, registered read
   always_ff @(posedge clock) begin
      if (own_wr) begin
         owner_mem[mem_addr] <= page;
      end
      if (stamp_wr) begin
         stamp_mem[mem_addr] <= count_ff;
      end
      owner_rd <= owner_mem[mem_addr];
      stamp_rd <= in_use_ff[mem_addr] ? stamp_mem[mem_addr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= REPL_FIFO;
         tlb_fill_ff  <= '0;
         claim_ff     <= '0;
         count_ff     <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         for (int i = 0; i < TLB_ENTRIES; i++) tlb_valid_ff[i] <= 1'b0;
         for (int i = 0; i < FRAME_COUNT; i++) in_use_ff[i] <= 1'b0;
      end else begin
         if (csr_wr_en) mode_ff <= csr_wr_data;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         rd_idx_ff <= mem_addr;
         case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  va_ff    <= req.data.virtual_address;
                  if (count_ff != '1) count_ff <= count_ff + 1'b1;
                  hit_ff   <= 1'b0;
                  fault_ff <= 1'b0;
                  state_ff <= ST_TLB;
               end
            end
            ST_TLB: begin
               idx_ff    <= '0;
               rd_vld_ff <= 1'b0;
               if (tlb_hit_c) begin
                  hit_ff   <= 1'b1;
                  frame_ff <= tlb_frame_c;
                  state_ff <= ST_WRITE;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // walk owners; read data arrives registered, alongside rd_idx
               rd_vld_ff <= (idx_ff < FRAME_COUNT);
               idx_ff    <= idx_ff + 1'b1;
               if (rd_vld_ff && in_use_ff[rd_idx_ff] && owner_rd == page) begin
                  frame_ff <= rd_idx_ff;
                  state_ff <= ST_WRITE;
               end else if (!rd_vld_ff && idx_ff != '0) begin
                  fault_ff <= 1'b1;
                  idx_ff   <= '0;
                  if (mode_ff == REPL_FIFO) begin
                     frame_ff <= claim_ff;
                     claim_ff <= (claim_ff == FW'(FRAME_COUNT - 1)) ? '0
                                                                   : claim_ff + 1'b1;
                     state_ff <= ST_EVICT;
                  end else begin
                     state_ff <= ST_FREE;
                  end
               end
            end
            ST_FREE: begin
               // lowest free frame, from the in-use flops
               state_ff <= ST_AGE;
               idx_ff   <= '0;
               rd_vld_ff <= 1'b0;
               for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
                  if (!in_use_ff[i]) begin
                     frame_ff <= FW'(i);
                     state_ff <= ST_EVICT;
                  end
               end
               if (state_ff == ST_FREE) begin
                  for (int i = 0; i < FRAME_COUNT; i++) begin
                     if (!in_use_ff[i]) begin
                        claim_ff <= (claim_ff == FW'(FRAME_COUNT - 1)) ? '0
                                                                      : claim_ff + 1'b1;
                     end
                  end
               end
            end
            ST_AGE: begin
               // all frames in use: oldest stamp, lowest index on ties
               rd_vld_ff <= (idx_ff < FRAME_COUNT);
               idx_ff    <= idx_ff + 1'b1;
               if (rd_vld_ff) begin
                  if (rd_idx_ff == '0 || stamp_rd < best_stamp_ff) begin
                     best_ff       <= rd_idx_ff;
                     best_stamp_ff <= stamp_rd;
                  end
               end else if (idx_ff != '0) begin
                  frame_ff <= best_ff;
                  state_ff <= ST_EVICT;
               end
            end
            ST_EVICT: begin
               // owner of frame_ff is read this cycle; use it next cycle
               state_ff <= ST_WRITE;
               rd_vld_ff <= 1'b1;
            end
            ST_WRITE: begin
               if (fault_ff) begin
                  rsp_ff.victim_valid <= in_use_ff[frame_ff];
                  rsp_ff.victim_page  <= in_use_ff[frame_ff] ? owner_rd : '0;
                  if (in_use_ff[frame_ff]) begin
                     for (int i = 0; i < TLB_ENTRIES; i++) begin
                        if (tlb_valid_ff[i] && tlb_page_ff[i] == owner_rd)
                           tlb_valid_ff[i] <= 1'b0;
                     end
                  end
                  in_use_ff[frame_ff] <= 1'b1;
               end else begin
                  rsp_ff.victim_valid <= 1'b0;
                  rsp_ff.victim_page  <= '0;
               end
               if (!hit_ff) begin
                  tlb_page_ff[tlb_fill_ff]  <= page;
                  tlb_frame_ff[tlb_fill_ff] <= frame_ff;
                  tlb_valid_ff[tlb_fill_ff] <= 1'b1;
                  tlb_fill_ff <= (tlb_fill_ff == TW'(TLB_ENTRIES - 1)) ? '0
                                                                       : tlb_fill_ff + 1'b1;
               end
               rsp_ff.phys_addr    <= PA_WIDTH'({frame_ff, va_ff[OFS_WIDTH-1:0]});
               rsp_ff.frame_number <= FRAME_WIDTH'(frame_ff);
               rsp_ff.tlb_hit      <= hit_ff;
               rsp_ff.page_fault   <= fault_ff;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* verif/tlb_page_translate_fifo_lru_core_tb.sv */
// ----------------------------------------------------------------------------
// tlb_page_translate_fifo_lru_core_tb
// Drives virtual addresses through the translation block under FIFO and LRU
// replacement, predicts every translation word from a behavioral copy of the
// TLB and frame table, and compares each response field by field.
// ----------------------------------------------------------------------------
module tlb_page_translate_fifo_lru_core_tb;
   import tlbpt_pkg::*;

   localparam int NTLB   = 16;
   localparam int NFRAME = 256;
   localparam longint CYCLE_LIMIT = 64'd4_000_000;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   tlbpt_req_if req_ch ();
   tlbpt_rsp_if rsp_ch ();

   tlb_page_translate_fifo_lru_core #(
      .TLB_ENTRIES (NTLB),
      .FRAME_COUNT (NFRAME)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch.sink),
      .rsp         (rsp_ch.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Translation state mirrored from the block's behavior.
   logic                   mode_q;
   logic                   tlb_vld [NTLB];
   logic [PAGE_WIDTH-1:0]  tlb_pg [NTLB];
   logic [FRAME_WIDTH-1:0] tlb_fr [NTLB];
   int unsigned            tlb_fill;
   logic                   fr_used [NFRAME];
   logic [PAGE_WIDTH-1:0]  fr_owner [NFRAME];
   logic [STAMP_WIDTH-1:0] fr_stamp [NFRAME];
   int unsigned            claim_ptr;
   logic [STAMP_WIDTH-1:0] access_cnt;

   rsp_word_type pending_xlat[$];
   int   fail_count;
   int   send_idle_pct;
   int   recv_stall_pct;
   longint cycle_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stop everything on a runaway run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tlb_page_translate_fifo_lru_core verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp_v);
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at cycle %0d",
               what, got, exp_v, cycle_count);
      fail_count++;
   endtask

   task automatic reset_model();
      mode_q     = REPL_FIFO;
      tlb_fill   = 0;
      claim_ptr  = 0;
      access_cnt = '0;
      for (int i = 0; i < NTLB; i++) begin
         tlb_vld[i] = 1'b0;
         tlb_pg[i]  = '0;
         tlb_fr[i]  = '0;
      end
      for (int i = 0; i < NFRAME; i++) begin
         fr_used[i]  = 1'b0;
         fr_owner[i] = '0;
         fr_stamp[i] = '0;
      end
   endtask

   // Compute the translation word for one address and update the mirror.
   function automatic rsp_word_type translate_address(input logic [VA_WIDTH-1:0] va);
      rsp_word_type           w;
      logic [PAGE_WIDTH-1:0]  pg;
      logic [OFS_WIDTH-1:0]   ofs;
      int unsigned            fr;
      bit                     hit, found;
      int unsigned            best;
      pg  = va[VA_WIDTH-1:OFS_WIDTH];
      ofs = va[OFS_WIDTH-1:0];
      w   = '0;
      hit = 0;
      found = 0;
      fr  = 0;
      if (access_cnt != '1) access_cnt++;
      for (int i = 0; i < NTLB; i++) begin
         if (!hit && tlb_vld[i] && tlb_pg[i] == pg) begin
            hit = 1;
            fr  = 32'(tlb_fr[i]);
         end
      end
      if (hit) begin
         fr_stamp[fr] = access_cnt;
      end else begin
         for (int i = 0; i < NFRAME; i++) begin
            if (!found && fr_used[i] && fr_owner[i] == pg) begin
               found = 1;
               fr    = i;
            end
         end
         if (!found) begin
            w.page_fault = 1'b1;
            if (mode_q == REPL_FIFO) begin
               fr = claim_ptr;
               claim_ptr = (claim_ptr + 1) % NFRAME;
            end else begin
               best = NFRAME;
               for (int i = 0; i < NFRAME; i++)
                  if (best == NFRAME && !fr_used[i]) best = i;
               if (best != NFRAME) begin
                  claim_ptr = (claim_ptr + 1) % NFRAME;
               end else begin
                  best = 0;
                  for (int i = 1; i < NFRAME; i++)
                     if (fr_stamp[i] < fr_stamp[best]) best = i;
               end
               fr = best;
            end
            if (fr_used[fr]) begin
               w.victim_valid = 1'b1;
               w.victim_page  = fr_owner[fr];
               // Drop stale TLB entries of the evicted page.
               for (int i = 0; i < NTLB; i++)
                  if (tlb_vld[i] && tlb_pg[i] == fr_owner[fr]) tlb_vld[i] = 1'b0;
            end
            fr_owner[fr] = pg;
            fr_used[fr]  = 1'b1;
         end
         fr_stamp[fr] = access_cnt;
         tlb_pg[tlb_fill]  = pg;
         tlb_fr[tlb_fill]  = fr[FRAME_WIDTH-1:0];
         tlb_vld[tlb_fill] = 1'b1;
         tlb_fill = (tlb_fill + 1) % NTLB;
      end
      w.frame_number = fr[FRAME_WIDTH-1:0];
      w.phys_addr    = {fr[FRAME_WIDTH-1:0], ofs};
      w.tlb_hit      = hit;
      return w;
   endfunction

   // Send one word; idle beforehand at the current rate. Valid stays high
   // after acceptance until the next word or a drain drops it.
   task automatic send_address(input logic [VA_WIDTH-1:0] va);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= va;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // The word was taken at this edge.
      pending_xlat.push_back(translate_address(va));
   endtask

   // Receiver: randomly stall, check every accepted word.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_xlat.size() == 0) begin
               report_mismatch("unexpected word", 64'(rsp_ch.data), 64'(0));
            end else begin
               rsp_word_type e;
               e = pending_xlat.pop_front();
               if (rsp_ch.data.phys_addr !== e.phys_addr)
                  report_mismatch("phys_addr", 64'(rsp_ch.data.phys_addr),
                                  64'(e.phys_addr));
               if (rsp_ch.data.frame_number !== e.frame_number)
                  report_mismatch("frame_number", 64'(rsp_ch.data.frame_number),
                                  64'(e.frame_number));
               if (rsp_ch.data.tlb_hit !== e.tlb_hit)
                  report_mismatch("tlb_hit", 64'(rsp_ch.data.tlb_hit), 64'(e.tlb_hit));
               if (rsp_ch.data.page_fault !== e.page_fault)
                  report_mismatch("page_fault", 64'(rsp_ch.data.page_fault),
                                  64'(e.page_fault));
               if (rsp_ch.data.victim_valid !== e.victim_valid)
                  report_mismatch("victim_valid", 64'(rsp_ch.data.victim_valid),
                                  64'(e.victim_valid));
               if (rsp_ch.data.victim_page !== e.victim_page)
                  report_mismatch("victim_page", 64'(rsp_ch.data.victim_page),
                                  64'(e.victim_page));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Drop valid, then hold until every outstanding word has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_xlat.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      mode_q = m;
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(input int snd, input int rcv);
      send_idle_pct  = snd;
      recv_stall_pct = rcv;
   endtask

   function automatic logic [VA_WIDTH-1:0] make_va(input int pg, input int ofs);
      return {pg[PAGE_WIDTH-1:0], ofs[OFS_WIDTH-1:0]};
   endfunction

   // Extremes, TLB hit, frame-table hit after TLB rollover.
   task automatic test_directed_fifo();
      send_address(20'h00000);
      send_address(20'hFFFFF);
      send_address(20'h003FF);        // same page zero: TLB hit
      send_address(20'hFFC00);        // top page, offset zero: TLB hit
      send_address(20'hAAAAA);
      send_address(20'h55555);
      for (int i = 0; i < 17; i++) send_address(make_va(100 + i, i * 61));
      send_address(20'h00155);        // page zero evicted from TLB, still mapped
   endtask

   // Fill all frames under FIFO and wrap around the frame table.
   task automatic test_fifo_wrap();
      for (int i = 0; i < 300; i++) begin
         send_address(make_va(200 + (i % 500), $urandom_range(1023)));
         if (i % 7 == 0) send_address(make_va(200 + (i % 500), $urandom_range(1023)));
      end
   endtask

   // LRU: every frame is already in use, so faults take the oldest stamp with ties at lowest index.
   task automatic test_lru_evict();
      int pg;
      for (int i = 0; i < 450; i++) begin
         case ($urandom_range(3))
            0: pg = $urandom_range(15);          // hot pages, mostly hits
            1: pg = $urandom_range(300);
            default: pg = $urandom_range(1023);
         endcase
         send_address(make_va(pg, $urandom_range(1023)));
      end
   endtask

   task automatic test_random_mix(input int n);
      int pg;
      for (int i = 0; i < n; i++) begin
         pg = ($urandom_range(1)) ? $urandom_range(40) : $urandom_range(1023);
         send_address(make_va(pg, $urandom_range(1023)));
      end
   endtask

   initial begin
      cycle_count  = 0;
      fail_count   = 0;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      set_idling(0, 0);
      reset_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_fifo();
      set_idling(48, 0);
      test_fifo_wrap();
      wait_drained();                    // pause until all words are back
      write_mode(REPL_LRU);
      set_idling(0, 48);
      test_lru_evict();
      write_mode(REPL_FIFO);
      set_idling(13, 13);
      test_random_mix(250);
      write_mode(REPL_LRU);
      set_idling(0, 0);
      test_random_mix(250);

      wait_drained();
      repeat (800) @(posedge clock);
      if (fail_count == 0) begin
         $display("tlb_page_translate_fifo_lru_core verification clean");
      end else begin
         $display("tlb_page_translate_fifo_lru_core verification failed");
      end
      $finish;
   end

endmodule
